FILE: rtl/cdisp_pkg.sv
// Shared types, codes and helpers for the CAN transmit frame dispatcher.
// No dependencies; every other file in rtl/ except cdisp_ram imports this package.
package cdisp_pkg;

	localparam int CHANNELS_DEF    = 2;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CMDQ_DEPTH      = 2;

	localparam int ID_W    = 29;
	localparam int LEN_W   = 4;
	localparam int DATA_W  = 64;
	localparam int LEVEL_W = 5;
	localparam int CFG_W   = 16;
	localparam int REG_W   = 1;
	localparam int TIME_W  = 32;

	localparam logic [LEN_W-1:0] LEN_MASK = 4'h0f;
	localparam logic [LEN_W-1:0] LEN_MAX  = 4'd8;
	localparam logic [7:0]       INFO_RTR = 8'h40;
	localparam logic [7:0]       INFO_EXT = 8'h80;

	localparam logic [CFG_W-1:0] TX_TIMEOUT_RST  = 16'd100;
	localparam logic [CFG_W-1:0] BUSOFF_HOLD_RST = 16'd1000;

	localparam logic [REG_W-1:0] REG_TX_TIMEOUT  = 1'd0;
	localparam logic [REG_W-1:0] REG_BUSOFF_HOLD = 1'd1;

	localparam logic [2:0] REQ_ENQUEUE = 3'd0;
	localparam logic [2:0] REQ_TICK    = 3'd1;
	localparam logic [2:0] REQ_DONE    = 3'd2;
	localparam logic [2:0] REQ_BUSOFF  = 3'd3;
	localparam logic [2:0] REQ_FLUSH   = 3'd4;

	typedef enum logic [2:0] {
		CMD_ENQ,
		CMD_TICK,
		CMD_DONE,
		CMD_BUSOFF,
		CMD_FLUSH,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic              channel;
		logic              extended;
		logic              remote;
		logic [LEN_W-1:0]  length;
		logic [ID_W-1:0]   identifier;
		logic [DATA_W-1:0] payload;
		logic              tx_buffer_free;
	} req_word_t;

	typedef struct packed {
		logic               started;
		logic               out_channel;
		logic [7:0]         frame_info;
		logic [31:0]        id_bytes;
		logic [DATA_W-1:0]  out_payload;
		logic [LEN_W-1:0]   out_length;
		logic               enqueue_dropped;
		logic               frame_lost;
		logic [LEVEL_W-1:0] queue_level;
	} rsp_word_t;

	typedef struct packed {
		logic             ext;
		logic             rem;
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0]  id;
	} hdr_t;

	localparam int ENTRY_W = $bits(hdr_t) + DATA_W;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              in_range;
		logic              channel;
		logic              buf_free;
		hdr_t              hdr;
		logic [DATA_W-1:0] data;
	} cmd_t;

	function automatic logic [31:0] encode_id(input logic ext, input logic [ID_W-1:0] id);
		logic [31:0] idb;
		if (ext) begin
			idb = {id[28:21], id[20:13], id[12:5], id[4:0], 3'b000};
		end else begin
			idb = {id[10:3], id[2:0], 5'b00000, 16'h0000};
		end
		return idb;
	endfunction

	function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		for (int b = 0; b < DATA_W / 8; b++) begin
			m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

endpackage

FILE: rtl/can_tx_frame_dispatcher.sv
// Top level of the CAN transmit frame dispatcher.
// Depends on cdisp_pkg, cdisp_front, cdisp_cmdq, cdisp_back and cdisp_ram.
//
// One frame queue per channel in a shared frame store. Request words are classified on entry
// and held in a two-entry command queue, so req_stall rises only when that queue is full.
// The back end takes one command at a time, through its idle and execute states and, when a
// dispatch pops a frame, the emit state for the registered frame store read. Each word gives
// exactly one response word, held in an output register until taken. The frame store needs no
// clearing after reset. The user must write configuration only while idle; nothing enforces it.
module can_tx_frame_dispatcher #(
	parameter int CHANNELS    = cdisp_pkg::CHANNELS_DEF,
	parameter int QUEUE_DEPTH = cdisp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cdisp_pkg::REG_W-1:0] cfg_index,
	input  logic [cdisp_pkg::CFG_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  cdisp_pkg::req_word_t        req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output cdisp_pkg::rsp_word_t        rsp
);
	import cdisp_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	cdisp_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	cdisp_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty)
	);

	cdisp_back #(
		.CHANNELS   (CHANNELS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/cdisp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cdisp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/cdisp_front.sv
// Front end: takes request words, classifies them and builds the queued frame header.
// Depends on cdisp_pkg.
module cdisp_front #(
	parameter int CHANNELS = 2
) (
	input  logic                 req_valid,
	output logic                 req_stall,
	input  cdisp_pkg::req_word_t req,
	input  logic                 q_full,
	output logic                 push,
	output cdisp_pkg::cmd_t      cmd
);
	import cdisp_pkg::*;

	cmd_kind_t        kind;
	logic [LEN_W-1:0] len_sat;

	always_comb begin
		case (req.req_type)
			REQ_ENQUEUE: kind = CMD_ENQ;
			REQ_TICK:    kind = CMD_TICK;
			REQ_DONE:    kind = CMD_DONE;
			REQ_BUSOFF:  kind = CMD_BUSOFF;
			REQ_FLUSH:   kind = CMD_FLUSH;
			default:     kind = CMD_NOP;
		endcase
	end

	assign len_sat = ((req.length & LEN_MASK) > LEN_MAX) ? LEN_MAX : (req.length & LEN_MASK);

	always_comb begin
		cmd.kind     = kind;
		cmd.in_range = (32'(req.channel) < 32'(CHANNELS));
		cmd.channel  = req.channel;
		cmd.buf_free = req.tx_buffer_free;
		cmd.hdr.ext  = req.extended;
		cmd.hdr.rem  = req.remote;
		cmd.hdr.len  = len_sat;
		cmd.hdr.id   = req.identifier;
		cmd.data     = req.payload;
	end

	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

endmodule

FILE: rtl/cdisp_cmdq.sv
// Short command queue between the front and back ends.
// Depends on cdisp_pkg.
module cdisp_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cdisp_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output cdisp_pkg::cmd_t head,
	output logic            empty
);
	import cdisp_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             ent_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/cdisp_back.sv
// Back end: per-channel queues, timeout and hold-off checks, frame encoding, result register.
// Depends on cdisp_pkg and cdisp_ram.
module cdisp_back #(
	parameter int CHANNELS    = 2,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cdisp_pkg::REG_W-1:0]   cfg_index,
	input  logic [cdisp_pkg::CFG_W-1:0]   cfg_data,
	input  cdisp_pkg::cmd_t               head,
	input  logic                          empty,
	output logic                          pop,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output cdisp_pkg::rsp_word_t          rsp
);
	import cdisp_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH  = CHANNELS * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  tx_timeout_q;
	logic [CFG_W-1:0]  hold_ms_q;
	logic [TIME_W-1:0] time_ms_q;
	logic              idle_q     [CHANNELS];
	logic              hold_act_q [CHANNELS];
	logic [TIME_W-1:0] start_q    [CHANNELS];
	logic [TIME_W-1:0] hold_q     [CHANNELS];
	logic [PTR_W-1:0]  rd_ptr_q   [CHANNELS];
	logic [PTR_W-1:0]  wr_ptr_q   [CHANNELS];
	logic [CNT_W-1:0]  fill_q     [CHANNELS];

	cmd_t               cmd_q;
	logic               out_valid_q;
	rsp_word_t          out_q;
	logic               emit_ch_q;
	logic               emit_started_q;
	logic [LEVEL_W-1:0] emit_level_q;

	logic [CH_W-1:0]    ch;
	logic [CNT_W-1:0]   fill_cur;
	logic               take;
	logic               timed_out;
	logic               hold_block;
	logic               idle_eff;
	logic               is_disp;
	logic               go;
	logic               ch_full;
	logic               enq;
	logic [ADDR_W-1:0]  base_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] rd_data;
	hdr_t               rd_hdr;
	logic [CNT_W-1:0]   level_exec;
	rsp_word_t          rsp_exec;
	rsp_word_t          rsp_emit;

	assign ch       = CH_W'(cmd_q.channel);
	assign fill_cur = fill_q[ch];
	assign take     = out_valid_q && !rsp_stall;
	assign pop      = (state_q == ST_IDLE) && !empty && (!out_valid_q || take);

	assign timed_out  = (time_ms_q - start_q[ch]) >= TIME_W'(tx_timeout_q);
	assign hold_block = hold_act_q[ch] && ((time_ms_q - hold_q[ch]) < TIME_W'(hold_ms_q));
	assign idle_eff   = idle_q[ch] || timed_out || (cmd_q.kind == CMD_DONE);
	assign is_disp    = (cmd_q.kind == CMD_TICK) || (cmd_q.kind == CMD_DONE);
	assign go         = (state_q == ST_EXEC) && cmd_q.in_range && is_disp && idle_eff
	                    && !hold_block && (fill_cur != '0);
	assign ch_full    = (fill_cur == CNT_W'(QUEUE_DEPTH));
	assign enq        = (state_q == ST_EXEC) && cmd_q.in_range && (cmd_q.kind == CMD_ENQ) && !ch_full;

	assign base_addr = ADDR_W'(ADDR_W'(ch) * ADDR_W'(QUEUE_DEPTH));
	assign rd_addr   = base_addr + ADDR_W'(rd_ptr_q[ch]);
	assign wr_addr   = base_addr + ADDR_W'(wr_ptr_q[ch]);

	cdisp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (enq),
		.wr_addr(wr_addr),
		.wr_data({cmd_q.hdr, cmd_q.data}),
		.rd_en  (go),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		case (cmd_q.kind)
			CMD_ENQ:   level_exec = ch_full ? fill_cur : fill_cur + CNT_W'(1);
			CMD_FLUSH: level_exec = '0;
			default:   level_exec = fill_cur;
		endcase
		rsp_exec                 = '0;
		rsp_exec.out_channel     = cmd_q.channel;
		rsp_exec.enqueue_dropped = cmd_q.in_range && (cmd_q.kind == CMD_ENQ) && ch_full;
		rsp_exec.queue_level     = cmd_q.in_range ? LEVEL_W'(level_exec) : '0;
	end

	assign rd_hdr = rd_data[ENTRY_W-1 -: $bits(hdr_t)];

	always_comb begin
		rsp_emit             = '0;
		rsp_emit.started     = emit_started_q;
		rsp_emit.frame_lost  = !emit_started_q;
		rsp_emit.out_channel = emit_ch_q;
		rsp_emit.frame_info  = {4'h0, rd_hdr.len & LEN_MASK}
		                       | (rd_hdr.rem ? INFO_RTR : 8'h00)
		                       | (rd_hdr.ext ? INFO_EXT : 8'h00);
		rsp_emit.id_bytes    = encode_id(rd_hdr.ext, rd_hdr.id);
		rsp_emit.out_payload = rd_data[DATA_W-1:0] & byte_mask(rd_hdr.len);
		rsp_emit.out_length  = rd_hdr.len;
		rsp_emit.queue_level = emit_level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			tx_timeout_q <= TX_TIMEOUT_RST;
			hold_ms_q    <= BUSOFF_HOLD_RST;
			time_ms_q    <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				idle_q[c]     <= 1'b1;
				hold_act_q[c] <= 1'b0;
				start_q[c]    <= '0;
				hold_q[c]     <= '0;
				rd_ptr_q[c]   <= '0;
				wr_ptr_q[c]   <= '0;
				fill_q[c]     <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TX_TIMEOUT:  tx_timeout_q <= cfg_data;
					REG_BUSOFF_HOLD: hold_ms_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == CMD_TICK) begin
							time_ms_q <= time_ms_q + TIME_W'(1);
						end
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q.in_range) begin
						case (cmd_q.kind)
							CMD_ENQ: begin
								if (!ch_full) begin
									wr_ptr_q[ch] <= (wr_ptr_q[ch] == PTR_W'(QUEUE_DEPTH - 1)) ?
									                '0 : wr_ptr_q[ch] + PTR_W'(1);
									fill_q[ch]   <= fill_cur + CNT_W'(1);
								end
							end
							CMD_TICK, CMD_DONE: begin
								idle_q[ch] <= (go && cmd_q.buf_free) ? 1'b0 : idle_eff;
								if (go) begin
									rd_ptr_q[ch] <= (rd_ptr_q[ch] == PTR_W'(QUEUE_DEPTH - 1)) ?
									                '0 : rd_ptr_q[ch] + PTR_W'(1);
									fill_q[ch]   <= fill_cur - CNT_W'(1);
									if (cmd_q.buf_free) begin
										start_q[ch] <= time_ms_q;
									end
								end
							end
							CMD_BUSOFF: begin
								hold_q[ch]     <= time_ms_q;
								hold_act_q[ch] <= 1'b1;
							end
							CMD_FLUSH: begin
								rd_ptr_q[ch] <= '0;
								wr_ptr_q[ch] <= '0;
								fill_q[ch]   <= '0;
								idle_q[ch]   <= 1'b1;
							end
							default: ;
						endcase
					end
					if (go) begin
						state_q <= ST_EMIT;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == ST_EXEC) begin
			if (go) begin
				emit_ch_q      <= cmd_q.channel;
				emit_started_q <= cmd_q.buf_free;
				emit_level_q   <= LEVEL_W'(fill_cur - CNT_W'(1));
			end else begin
				out_q <= rsp_exec;
			end
		end
		if (state_q == ST_EMIT) begin
			out_q <= rsp_emit;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTH
	a_emit_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ($past(state_q) == ST_EXEC))
		else $error("emit without a preceding dispatch");
	a_out_free_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result register busy while an item is executed");
	a_started_or_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.started && out_q.frame_lost))
		else $error("frame both started and lost");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EXEC) && cmd_q.in_range) |-> (fill_cur <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue fill beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (fill_cur != '0))
		else $error("pop from an empty channel queue");
`endif

endmodule
